// ===== rtl/tkmh_pkg.sv =====
// Shared types and constants for the bounded top-k min-heap.
// Used by tkmh_ctrl, tkmh_datapath and top_k_min_heap; depends on nothing.
`default_nettype none

package tkmh_pkg;

  // Heap capacity; one extra slot holds a record between append and removal.
  localparam int CAPACITY = 64;
  localparam int SLOTS    = CAPACITY + 1;
  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int CNT_W    = 7;
  localparam int K_W      = 7;
  localparam logic [K_W-1:0] K_RESET = 7'd10;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] new_score;
    logic        [31:0] new_payload;
  } tkmh_in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] min_score;
    logic        [31:0] min_payload;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
  } tkmh_out_t;

  // One heap entry.
  typedef struct packed {
    logic signed [31:0] score;
    logic        [31:0] tag;
  } tkmh_rec_t;

  // Commands from the controller to the datapath, one per controller step.
  typedef struct packed {
    logic take;     // latch the item and run the accept test
    logic up_chk;   // sift up: write at root or read the parent
    logic up_cmp;   // sift up: move parent down or place the record
    logic rm;       // remove root: shrink count, read the last entry
    logic dn_load;  // sift down: last entry becomes the moving record
    logic dn_chk;   // sift down: read left child or place the record
    logic dn_rdl;   // sift down: hold left child, read right child
    logic dn_rdr;   // sift down: pick the smallest, move it up or place
  } tkmh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ins_go;     // the presented insert enters the heap
    logic pos_zero;   // moving position is the root
    logic parent_gt;  // parent score is above the moving record
    logic need_rm;    // root must be removed for this item
    logic left_in;    // left child lies inside the heap
    logic best_moves; // a child is smaller than the moving record
  } tkmh_sts_t;

endpackage

`default_nettype wire

// ===== rtl/tkmh_ctrl.sv =====
// Controller state machine for the top-k min-heap: sequences insert,
// sift up, root removal and sift down. Depends on tkmh_pkg.
`default_nettype none

module tkmh_ctrl
  import tkmh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  output logic           done_o,
  input  wire tkmh_sts_t sts_i,
  output tkmh_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_CHK  = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_TRIM    = 4'd3;
  localparam logic [3:0] S_RM      = 4'd4;
  localparam logic [3:0] S_DN_LOAD = 4'd5;
  localparam logic [3:0] S_DN_CHK  = 4'd6;
  localparam logic [3:0] S_DN_RDL  = 4'd7;
  localparam logic [3:0] S_DN_RDR  = 4'd8;
  localparam logic [3:0] S_RESULT  = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = sts_i.ins_go ? S_UP_CHK : S_TRIM;
        end
      end
      S_UP_CHK:  state_d = sts_i.pos_zero ? S_TRIM : S_UP_CMP;
      S_UP_CMP:  state_d = sts_i.parent_gt ? S_UP_CHK : S_TRIM;
      S_TRIM:    state_d = sts_i.need_rm ? S_RM : S_RESULT;
      S_RM:      state_d = S_DN_LOAD;
      S_DN_LOAD: state_d = S_DN_CHK;
      S_DN_CHK:  state_d = sts_i.left_in ? S_DN_RDL : S_RESULT;
      S_DN_RDL:  state_d = S_DN_RDR;
      S_DN_RDR:  state_d = sts_i.best_moves ? S_DN_CHK : S_RESULT;
      S_RESULT:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESULT);

  assign cmd_o.take    = (state_q == S_IDLE) && start;
  assign cmd_o.up_chk  = (state_q == S_UP_CHK);
  assign cmd_o.up_cmp  = (state_q == S_UP_CMP);
  assign cmd_o.rm      = (state_q == S_RM);
  assign cmd_o.dn_load = (state_q == S_DN_LOAD);
  assign cmd_o.dn_chk  = (state_q == S_DN_CHK);
  assign cmd_o.dn_rdl  = (state_q == S_DN_RDL);
  assign cmd_o.dn_rdr  = (state_q == S_DN_RDR);

endmodule

`default_nettype wire

// ===== rtl/tkmh_datapath.sv =====
// Datapath for the top-k min-heap: heap memory, count, limit register,
// moving record and root copy. Depends on tkmh_pkg.
`default_nettype none

module tkmh_datapath
  import tkmh_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  input  wire logic [K_W-1:0] cfg_data_i,
  input  wire tkmh_in_t       in_i,
  input  wire tkmh_cmd_t      cmd_i,
  output tkmh_sts_t           sts_o,
  output tkmh_out_t           res_o
);

  tkmh_rec_t mem [0:SLOTS-1];

  logic [K_W-1:0]    k_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  tkmh_rec_t         x_q, x_d;
  tkmh_rec_t         lval_q;
  tkmh_rec_t         rdata_q;
  tkmh_rec_t         root_q;
  logic              func_q;
  logic              acc_q;

  logic [CNT_W-1:0]  lim;
  logic              take_ok;
  logic [ADDR_W-1:0] parent;
  logic [ADDR_W:0]   l_idx, r_idx, cnt_x;
  logic              left_in, right_in;
  logic              l_best, r_best, moves;
  tkmh_rec_t         bval, child;
  logic [ADDR_W-1:0] child_pos;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  tkmh_rec_t         wdata;

  // A limit of zero acts as one; a limit above capacity acts as capacity.
  always_comb begin
    priority if (k_q == '0) begin
      lim = CNT_W'(1);
    end else if (CNT_W'(k_q) > CNT_W'(CAPACITY)) begin
      lim = CNT_W'(CAPACITY);
    end else begin
      lim = CNT_W'(k_q);
    end
  end

  assign take_ok = (in_i.func == FUNC_INSERT) &&
                   ((cnt_q < lim) ||
                    ((cnt_q != '0) && (in_i.new_score > root_q.score))) &&
                   (cnt_q <= CNT_W'(CAPACITY));

  assign parent   = (pos_q - ADDR_W'(1)) >> 1;
  assign l_idx    = {pos_q, 1'b1};
  assign r_idx    = l_idx + (ADDR_W+1)'(1);
  assign cnt_x    = (ADDR_W+1)'(cnt_q);
  assign left_in  = (l_idx < cnt_x);
  assign right_in = (r_idx < cnt_x);

  // Smallest of the moving record and its children; ties keep the parent.
  assign l_best    = (x_q.score > lval_q.score);
  assign bval      = l_best ? lval_q : x_q;
  assign r_best    = right_in && (bval.score > rdata_q.score);
  assign moves     = l_best || r_best;
  assign child     = r_best ? rdata_q : lval_q;
  assign child_pos = r_best ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];

  assign sts_o.ins_go     = take_ok;
  assign sts_o.pos_zero   = (pos_q == '0);
  assign sts_o.parent_gt  = (rdata_q.score > x_q.score);
  assign sts_o.need_rm    = (func_q == FUNC_DELETE) ? (cnt_q != '0) : (cnt_q > lim);
  assign sts_o.left_in    = left_in;
  assign sts_o.best_moves = moves;

  // Memory port selection. The moving record stays out of memory until its
  // final slot is known; the entries it passes are shifted one level.
  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wdata = x_q;
    re    = 1'b0;
    raddr = parent;
    if (cmd_i.up_chk) begin
      if (pos_q == '0) begin
        we = 1'b1;
      end else begin
        re = 1'b1;
      end
    end
    if (cmd_i.up_cmp) begin
      we = 1'b1;
      if (rdata_q.score > x_q.score) begin
        wdata = rdata_q;
      end
    end
    if (cmd_i.rm) begin
      re    = 1'b1;
      raddr = ADDR_W'(cnt_q - CNT_W'(1));
    end
    if (cmd_i.dn_chk) begin
      if (left_in) begin
        re    = 1'b1;
        raddr = l_idx[ADDR_W-1:0];
      end else begin
        we = 1'b1;
      end
    end
    if (cmd_i.dn_rdl && right_in) begin
      re    = 1'b1;
      raddr = r_idx[ADDR_W-1:0];
    end
    if (cmd_i.dn_rdr) begin
      we = 1'b1;
      if (moves) begin
        wdata = child;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    x_d   = x_q;
    if (cmd_i.take) begin
      x_d.score = in_i.new_score;
      x_d.tag   = in_i.new_payload;
      pos_d     = ADDR_W'(cnt_q);
      if (take_ok) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
    if (cmd_i.up_cmp && (rdata_q.score > x_q.score)) begin
      pos_d = parent;
    end
    if (cmd_i.rm) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (cmd_i.dn_load) begin
      x_d   = rdata_q;
      pos_d = '0;
    end
    if (cmd_i.dn_rdr && moves) begin
      pos_d = child_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= K_RESET;
      cnt_q  <= '0;
      func_q <= FUNC_INSERT;
      acc_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        k_q <= cfg_data_i;
      end
      cnt_q <= cnt_d;
      if (cmd_i.take) begin
        func_q <= in_i.func;
        acc_q  <= take_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    x_q   <= x_d;
    if (cmd_i.dn_rdl) begin
      lval_q <= rdata_q;
    end
    if (we && (waddr == '0)) begin
      root_q <= wdata;
    end
  end

  assign res_o.accepted    = acc_q;
  assign res_o.min_score   = (cnt_q == '0) ? '0 : root_q.score;
  assign res_o.min_payload = (cnt_q == '0) ? '0 : root_q.tag;
  assign res_o.count       = cnt_q;
  assign res_o.is_empty    = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== rtl/top_k_min_heap.sv =====
// Top level of the bounded top-k min-heap: joins controller and datapath.
// Depends on tkmh_pkg, tkmh_ctrl and tkmh_datapath.
//
//   Channel   Signals                         Transfer condition
//   -------   -----------------------------   ------------------------------
//   item in   start, busy, in_i               start high while busy is low
//   result    done_o, res_o                   every cycle done_o is high
//   config    cfg_valid_i, cfg_ready_o,       cfg_valid_i high (ready is
//             cfg_data_i                      always high)
//
// One item at a time; busy is high after the transfer through the result cycle.
// An accepted insert climbs level by level toward the root, reading one parent
// per level; a removal of the root lets the last entry sink level by level
// toward a leaf, reading the left child and, if present, the right child per
// level. The heap memory has a single port with registered read data.
// Reset leaves the heap empty with a limit of ten; no clearing pass is run.
// The result stands for exactly one cycle and cannot be stalled.
`default_nettype none

module top_k_min_heap
  import tkmh_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire tkmh_in_t       in_i,
  output logic                done_o,
  output tkmh_out_t           res_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [K_W-1:0] cfg_data_i
);

  tkmh_cmd_t cmd;
  tkmh_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tkmh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tkmh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for top_k_min_heap. A heap predictor follows every item
// transfer, and each one-cycle result is checked in order. Needs tkmh_pkg and the RTL.

module tb;
  import tkmh_pkg::*;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start;
  logic           busy;
  tkmh_in_t       item_bus;
  logic           done_o;
  tkmh_out_t      res_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [K_W-1:0] cfg_data_i;

  always #5 clk_i = ~clk_i;

  top_k_min_heap DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (item_bus),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Predicted heap contents, including the slot used between append and removal.
  logic signed [31:0] heap_score_m [0:CAPACITY];
  logic        [31:0] heap_tag_m   [0:CAPACITY];
  int unsigned        held_m;
  logic [K_W-1:0]     limit_m;
  tkmh_out_t          root_reports_q [$];

  int unsigned errors_n;
  int unsigned checked_n;
  int unsigned items_n;
  int unsigned taken_n;
  int unsigned empty_pops_n;
  int unsigned limits_n;
  int unsigned peak_held;
  int unsigned overflow_n;
  int unsigned pauses_n;

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [31:0] s;
    logic        [31:0] t;
    s               = heap_score_m[a];
    t               = heap_tag_m[a];
    heap_score_m[a] = heap_score_m[b];
    heap_tag_m[a]   = heap_tag_m[b];
    heap_score_m[b] = s;
    heap_tag_m[b]   = t;
  endfunction

  function automatic void float_up_last();
    int unsigned pos;
    int unsigned up;
    bit          walking;
    pos     = held_m - 1;
    walking = 1'b1;
    while (walking && pos > 0) begin
      up = (pos - 1) / 2;
      if (heap_score_m[up] > heap_score_m[pos]) begin
        swap_entries(up, pos);
        pos = up;
      end else begin
        walking = 1'b0;
      end
    end
  endfunction

  function automatic void sink_from_root();
    int unsigned pos;
    int unsigned lc;
    int unsigned rc;
    int unsigned low;
    bit          walking;
    pos     = 0;
    walking = 1'b1;
    while (walking) begin
      lc  = 2 * pos + 1;
      rc  = lc + 1;
      low = pos;
      if (lc >= held_m) begin
        walking = 1'b0;
      end else begin
        if (heap_score_m[pos] > heap_score_m[lc]) low = lc;
        if (rc < held_m && heap_score_m[low] > heap_score_m[rc]) low = rc;
        if (low == pos) begin
          walking = 1'b0;
        end else begin
          swap_entries(pos, low);
          pos = low;
        end
      end
    end
  endfunction

  function automatic void pop_min();
    if (held_m == 0) begin
      empty_pops_n++;
    end else begin
      held_m--;
      heap_score_m[0] = heap_score_m[held_m];
      heap_tag_m[0]   = heap_tag_m[held_m];
      sink_from_root();
    end
  endfunction

  // Applies one item to the predicted heap and returns the report it should give.
  function automatic tkmh_out_t heap_model_step(tkmh_in_t it);
    tkmh_out_t   r;
    int unsigned lim;
    r   = '0;
    lim = limit_m;
    if (lim == 0) lim = 1;
    if (lim > CAPACITY) lim = CAPACITY;
    if (it.func == FUNC_INSERT) begin
      if (held_m < lim ||
          (held_m > 0 && $signed(it.new_score) > $signed(heap_score_m[0]))) begin
        if (held_m <= CAPACITY) begin
          if (held_m == CAPACITY) overflow_n++;
          heap_score_m[held_m] = it.new_score;
          heap_tag_m[held_m]   = it.new_payload;
          held_m++;
          float_up_last();
          r.accepted = 1'b1;
          taken_n++;
          if (held_m > peak_held) peak_held = held_m;
        end
      end
      // A lowered limit drains by one record per insert, not all at once.
      if (held_m > lim) pop_min();
    end else begin
      pop_min();
    end
    r.count = CNT_W'(held_m);
    if (held_m == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.min_score   = heap_score_m[0];
      r.min_payload = heap_tag_m[0];
    end
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (errors_n < 40)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    errors_n++;
  endtask

  always @(posedge clk_i) begin
    tkmh_out_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (root_reports_q.size() == 0) begin
        if (errors_n < 40)
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, res_o);
        errors_n++;
      end else begin
        want = root_reports_q.pop_front();
        checked_n++;
        if (res_o.accepted !== want.accepted)
          note_mismatch("accepted", 32'(want.accepted), 32'(res_o.accepted));
        if (res_o.min_score !== want.min_score)
          note_mismatch("min_score", want.min_score, res_o.min_score);
        if (res_o.min_payload !== want.min_payload)
          note_mismatch("min_payload", want.min_payload, res_o.min_payload);
        if (res_o.count !== want.count)
          note_mismatch("count", 32'(want.count), 32'(res_o.count));
        if (res_o.is_empty !== want.is_empty)
          note_mismatch("is_empty", 32'(want.is_empty), 32'(res_o.is_empty));
      end
    end
  end

  task automatic wait_drained();
    while (root_reports_q.size() != 0) @(posedge clk_i);
  endtask

  // Start stays high between back-to-back items; it only drops for a gap.
  task automatic send_item(input logic func, input logic [31:0] score,
                           input logic [31:0] tag, input bit no_gap);
    tkmh_in_t    it;
    tkmh_out_t   predicted;
    int unsigned gap;
    it.func        = func;
    it.new_score   = score;
    it.new_payload = tag;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    item_bus <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted      = heap_model_step(it);
    root_reports_q = {root_reports_q, predicted};
    items_n++;
  endtask

  task automatic write_limit(input logic [K_W-1:0] k);
    start <= 1'b0;
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    limit_m = k;
    limits_n++;
  endtask

  task automatic test_empty_heap();
    send_item(FUNC_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_item(FUNC_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_item(FUNC_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(FUNC_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_item(FUNC_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(FUNC_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0);
  endtask

  // A limit of zero behaves as one; ties and lower scores are turned away.
  task automatic test_single_slot();
    write_limit(7'd0);
    send_item(FUNC_INSERT, 32'h0005_0000, 32'h0000_0A01, 1'b0);
    send_item(FUNC_INSERT, 32'h0005_0000, 32'h0000_0A02, 1'b1);
    send_item(FUNC_INSERT, 32'h0003_0000, 32'h0000_0A03, 1'b0);
    send_item(FUNC_INSERT, 32'h0009_8000, 32'h0000_0A04, 1'b0);
  endtask

  task automatic test_limit_lowered();
    write_limit(7'd5);
    send_item(FUNC_INSERT, 32'h0064_0000, 32'h0000_0B01, 1'b0);
    send_item(FUNC_INSERT, 32'hFF38_0000, 32'h0000_0B02, 1'b1);
    send_item(FUNC_INSERT, 32'h012C_0000, 32'h0000_0B03, 1'b1);
    send_item(FUNC_INSERT, 32'h0000_0000, 32'h0000_0B04, 1'b0);
    send_item(FUNC_INSERT, 32'h0032_0000, 32'h0000_0B05, 1'b0);
    write_limit(7'd2);
    send_item(FUNC_INSERT, 32'hFC18_0000, 32'h0000_0B06, 1'b0);
    send_item(FUNC_INSERT, 32'h03E8_0000, 32'h0000_0B07, 1'b1);
    send_item(FUNC_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_item(FUNC_INSERT, 32'h0000_0001, 32'h0000_0B08, 1'b0);
  endtask

  // Phases of random items under a range of limits; a high limit after a low
  // one fills the heap, a low limit after a high one drains it gradually.
  task automatic test_random_phases();
    int unsigned    p;
    int unsigned    n;
    int unsigned    ins_pct;
    int unsigned    style;
    bit             burst;
    logic [K_W-1:0] k;
    logic [31:0]    score;
    logic [31:0]    rise_base;
    logic           func;
    for (p = 0; p < 12; p++) begin
      case (p)
        0:       k = 7'd127;
        1:       k = 7'd3;
        2:       k = 7'd64;
        4:       k = 7'd1;
        5:       k = 7'd0;
        6:       k = 7'd10;
        8:       k = 7'd64;
        9:       k = 7'd2;
        10:      k = 7'd40;
        default: k = K_W'($urandom_range(0, 127));
      endcase
      write_limit(k);
      ins_pct   = (k >= 40) ? 92 : $urandom_range(55, 90);
      style     = $urandom_range(0, 2);
      burst     = ($urandom_range(0, 3) == 0);
      rise_base = $urandom;
      for (n = 0; n < 85; n++) begin
        func = ($urandom_range(1, 100) <= ins_pct) ? FUNC_INSERT : FUNC_DELETE;
        case (style)
          0: score = $urandom;
          1: score = $urandom_range(0, 15) - 8;  // narrow band, many equal scores
          default: begin
            rise_base = rise_base + $urandom_range(0, 32'h0003_0000);
            score     = rise_base;
          end
        endcase
        if ($urandom_range(0, 19) == 0)
          score = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if ($urandom_range(0, 39) == 0) begin
          start <= 1'b0;
          wait_drained();
          @(posedge clk_i);
          pauses_n++;
        end
        send_item(func, score, $urandom, burst);
      end
    end
  endtask

  initial begin
    start       <= 1'b0;
    item_bus    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    held_m       = 0;
    limit_m      = K_RESET;
    errors_n     = 0;
    checked_n    = 0;
    items_n      = 0;
    taken_n      = 0;
    empty_pops_n = 0;
    limits_n     = 0;
    peak_held    = 0;
    overflow_n   = 0;
    pauses_n     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_heap();
    test_single_slot();
    test_limit_lowered();
    test_random_phases();

    start <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk_i);

    $display("Covered %0d items: %0d inserts taken, %0d removals on an empty heap,",
             items_n, taken_n, empty_pops_n);
    $display("%0d limit writes. Peak fill %0d of %0d, %0d overflow-slot inserts,",
             limits_n, peak_held, CAPACITY, overflow_n);
    $display("%0d results checked, %0d pauses.", checked_n, pauses_n);
    if (errors_n == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
